>>> hdl/nes_pkg.sv
// shared types and constants for the neighborhood elevation statistics block
package nes_pkg;

    localparam int MAX_NEIGHBORS = 64;
    localparam int Z_W           = 32;
    localparam int CNT_W         = 7;
    localparam int ADDR_W        = 6;
    localparam int SUM_W         = 38;
    localparam int ACC_W         = 70;
    localparam int DVS_W         = 32;
    localparam int DIV_STEPS     = 70;
    localparam int STEP_W        = 7;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TOO_FEW  = 2'd1;
    localparam logic [1:0] STATUS_DEGEN    = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    localparam logic [7:0] CFG_USE_MIN_COUNT = 8'd0;
    localparam logic [7:0] CFG_MIN_NEIGHBORS = 8'd1;

    localparam logic signed [23:0] SCORE_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SCORE_MIN = -24'sh800000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MEAN_DIV,
        ST_SQ_RD,
        ST_SQ_DIF,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_VAR_DIV,
        ST_ROOT,
        ST_SCORE_DIV,
        ST_OUT
    } state_t;

endpackage

>>> hdl/neighborhood_elevation_stats.sv
// neighborhood elevation statistics: top level with store, sequencer and shared units
//
// A center item (kind 0) opens a set and holds the center elevation; neighbor items
// (kind 1) are stored, summed and tracked for min and max, one per cycle. The neighbor
// that carries last_neighbor closes the set and yields one result item: the rounded
// mean, center minus mean, max minus min, the sample standard deviation (two-pass,
// divide by n-1, floor square root) and the z-score in Q7.16, saturated. Up to 64
// neighbors are kept; extras are dropped and flagged with status 3 when a score is
// computed. Closing a set runs a check state, one shared 70-step restoring divider
// used up to three times (mean, variance, score), a second pass over the store (read,
// difference, square, accumulate per neighbor) through one 32x32 squarer and a 32-step
// square root, then loads the result into the output register. Sets with too few
// neighbors or none skip to the output; one neighbor stops after the mean division;
// a zero deviation skips the score division. The load waits while the output register
// still holds an item that is not yet taken. in_ready is low from the closing neighbor
// until its result is loaded into the output register and high for every other item.
// Configuration writes are taken at any time and are meant to be issued while the
// block is idle.
module neighborhood_elevation_stats (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    // input items
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic signed [31:0] z_value,
    input  logic               last_neighbor,
    // result items
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [6:0]         neighbor_total,
    output logic signed [31:0] mean_z,
    output logic signed [32:0] diff_from_mean,
    output logic [31:0]        z_range,
    output logic [31:0]        std_dev,
    output logic signed [23:0] deviation_score
);
    import nes_pkg::*;

    // control and set state
    state_t                   state_reg, state_next;
    logic                     use_min_reg;
    logic [CNT_W-1:0]         min_nb_reg;
    logic [CNT_W-1:0]         count_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [Z_W-1:0]    max_reg;
    logic signed [Z_W-1:0]    min_reg;
    logic signed [Z_W-1:0]    center_reg;
    logic                     drop_reg;
    logic                     out_valid_reg;

    // neighbor store
    logic [Z_W-1:0]           mem_reg [MAX_NEIGHBORS];
    logic [Z_W-1:0]           rd_data_reg;
    logic [CNT_W-1:0]         idx_reg;

    // working values
    logic signed [Z_W-1:0]    mean_reg;
    logic signed [Z_W:0]      diff_reg;
    logic [Z_W-1:0]           range_reg;
    logic [Z_W-1:0]           sd_reg;
    logic signed [23:0]       score_reg;
    logic [1:0]               stat_reg;
    logic                     neg_reg;
    logic [Z_W-1:0]           absd_reg;
    logic [63:0]              sq_reg;
    logic [ACC_W-1:0]         acc_reg;

    // shared divider
    logic [ACC_W-1:0]         div_quo_reg;
    logic [DVS_W:0]           div_rem_reg;
    logic [DVS_W-1:0]         div_dvs_reg;
    logic [STEP_W-1:0]        div_cnt_reg;

    // square root unit
    logic [63:0]              rt_x_reg;
    logic [63:0]              rt_res_reg;
    logic [63:0]              rt_bit_reg;

    // output register payload
    logic [1:0]               o_status_reg;
    logic [CNT_W-1:0]         o_total_reg;
    logic signed [31:0]       o_mean_reg;
    logic signed [32:0]       o_diff_reg;
    logic [31:0]              o_range_reg;
    logic [31:0]              o_sd_reg;
    logic signed [23:0]       o_score_reg;

    logic                     in_fire;
    logic                     nb_fire;
    logic                     too_few;
    logic                     out_load;
    logic                     div_busy;
    logic                     div_load;
    logic [ACC_W-1:0]         div_dividend;
    logic [DVS_W-1:0]         div_divisor;
    logic [DVS_W+1:0]         rem_shift;
    logic                     rem_ge;
    logic [DVS_W+1:0]         rem_sub;
    logic [SUM_W-1:0]         sum_mag;
    logic signed [Z_W:0]      d_val;
    logic [Z_W:0]             d_mag;
    logic [63:0]              rt_trial;
    logic [Z_W:0]             diff_mag;
    logic [63:0]              var_sat;
    logic signed [SUM_W-1:0]  z_ext;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign nb_fire   = in_fire && kind;
    assign too_few   = use_min_reg && (count_reg < min_nb_reg);
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    assign z_ext     = SUM_W'(z_value);

    // divider step: one quotient bit a cycle
    assign div_busy  = (div_cnt_reg != '0);
    assign rem_shift = {div_rem_reg, div_quo_reg[ACC_W-1]};
    assign rem_ge    = (rem_shift >= {2'b00, div_dvs_reg});
    assign rem_sub   = rem_shift - {2'b00, div_dvs_reg};

    // magnitudes for the mean, the deviation pass and the score
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign d_val     = $signed({rd_data_reg[Z_W-1], rd_data_reg})
                     - $signed({mean_reg[Z_W-1], mean_reg});
    assign d_mag     = d_val[Z_W] ? (Z_W+1)'(-d_val) : (Z_W+1)'(d_val);
    assign diff_mag  = diff_reg[Z_W] ? (Z_W+1)'(-diff_reg) : (Z_W+1)'(diff_reg);
    assign rt_trial  = rt_res_reg + rt_bit_reg;
    // variance saturates when the quotient does not fit 64 bits
    assign var_sat   = (div_quo_reg[ACC_W-1:64] != '0) ? '1 : div_quo_reg[63:0];

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        div_load     = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (nb_fire && last_neighbor)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (too_few || count_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    div_load     = 1'b1;
                    div_dividend = ACC_W'(sum_mag) + ACC_W'(count_reg >> 1);
                    div_divisor  = DVS_W'(count_reg);
                    state_next   = ST_MEAN_DIV;
                end
            end
            ST_MEAN_DIV:
            begin
                if (!div_busy)
                    state_next = (count_reg >= CNT_W'(2)) ? ST_SQ_RD : ST_OUT;
            end
            ST_SQ_RD:  state_next = ST_SQ_DIF;
            ST_SQ_DIF: state_next = ST_SQ_MUL;
            ST_SQ_MUL: state_next = ST_SQ_ACC;
            ST_SQ_ACC:
            begin
                if (idx_reg + CNT_W'(1) == count_reg)
                begin
                    div_load     = 1'b1;
                    div_dividend = acc_reg + ACC_W'(sq_reg);
                    div_divisor  = DVS_W'(count_reg - CNT_W'(1));
                    state_next   = ST_VAR_DIV;
                end
                else
                begin
                    state_next = ST_SQ_RD;
                end
            end
            ST_VAR_DIV:
            begin
                if (!div_busy)
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (rt_bit_reg == '0)
                begin
                    if (rt_res_reg[Z_W-1:0] == '0)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        div_load     = 1'b1;
                        div_dividend = ACC_W'({diff_mag, 16'h0000})
                                     + ACC_W'(rt_res_reg[Z_W-1:1]);
                        div_divisor  = rt_res_reg[Z_W-1:0];
                        state_next   = ST_SCORE_DIV;
                    end
                end
            end
            ST_SCORE_DIV:
            begin
                if (!div_busy)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_min_reg <= 1'b0;
            min_nb_reg  <= CNT_W'(3);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_USE_MIN_COUNT)
                use_min_reg <= cfg_data[0];
            else if (cfg_index == CFG_MIN_NEIGHBORS)
                min_nb_reg <= cfg_data[CNT_W-1:0];
        end
    end

    // set accumulation; cleared by a center item and when a result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_reg    <= '0;
            max_reg    <= 32'sh80000000;
            min_reg    <= 32'sh7FFFFFFF;
            center_reg <= '0;
            drop_reg   <= 1'b0;
        end
        else if (in_fire && !kind)
        begin
            center_reg <= z_value;
            count_reg  <= '0;
            sum_reg    <= '0;
            max_reg    <= 32'sh80000000;
            min_reg    <= 32'sh7FFFFFFF;
            drop_reg   <= 1'b0;
        end
        else if (nb_fire)
        begin
            if (count_reg < CNT_W'(MAX_NEIGHBORS))
            begin
                count_reg <= count_reg + CNT_W'(1);
                sum_reg   <= sum_reg + z_ext;
                if (z_value > max_reg)
                    max_reg <= z_value;
                if (z_value < min_reg)
                    min_reg <= z_value;
            end
            else
            begin
                drop_reg <= 1'b1;
            end
        end
        else if (out_load)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            max_reg   <= 32'sh80000000;
            min_reg   <= 32'sh7FFFFFFF;
            drop_reg  <= 1'b0;
        end
    end

    // neighbor store, registered read
    always_ff @(posedge clk)
    begin
        if (nb_fire && count_reg < CNT_W'(MAX_NEIGHBORS))
            mem_reg[count_reg[ADDR_W-1:0]] <= z_value;
        rd_data_reg <= mem_reg[idx_reg[ADDR_W-1:0]];
    end

    // shared divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (div_load)
            div_cnt_reg <= STEP_W'(DIV_STEPS);
        else if (div_busy)
            div_cnt_reg <= div_cnt_reg - STEP_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            div_quo_reg <= div_dividend;
            div_rem_reg <= '0;
            div_dvs_reg <= div_divisor;
        end
        else if (div_busy)
        begin
            div_quo_reg <= {div_quo_reg[ACC_W-2:0], rem_ge};
            div_rem_reg <= rem_ge ? rem_sub[DVS_W:0] : rem_shift[DVS_W:0];
        end
    end

    // datapath steps of the sequencer
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_CHECK:
            begin
                neg_reg   <= sum_reg[SUM_W-1];
                mean_reg  <= '0;
                diff_reg  <= '0;
                range_reg <= '0;
                sd_reg    <= '0;
                score_reg <= '0;
                stat_reg  <= too_few ? STATUS_TOO_FEW : STATUS_DEGEN;
            end
            ST_MEAN_DIV:
            begin
                if (!div_busy)
                begin
                    mean_reg  <= neg_reg ? -$signed(div_quo_reg[Z_W-1:0])
                                         : $signed(div_quo_reg[Z_W-1:0]);
                    diff_reg  <= $signed({center_reg[Z_W-1], center_reg})
                               - (neg_reg ? -$signed({1'b0, div_quo_reg[Z_W-1:0]})
                                          : $signed({1'b0, div_quo_reg[Z_W-1:0]}));
                    range_reg <= Z_W'(max_reg - min_reg);
                    idx_reg   <= '0;
                    acc_reg   <= '0;
                end
            end
            ST_SQ_DIF: absd_reg <= d_mag[Z_W-1:0];
            ST_SQ_MUL: sq_reg   <= absd_reg * absd_reg;
            ST_SQ_ACC:
            begin
                acc_reg <= acc_reg + ACC_W'(sq_reg);
                idx_reg <= idx_reg + CNT_W'(1);
            end
            ST_VAR_DIV:
            begin
                if (!div_busy)
                begin
                    rt_x_reg   <= var_sat;
                    rt_res_reg <= '0;
                    rt_bit_reg <= 64'h4000_0000_0000_0000;
                end
            end
            ST_ROOT:
            begin
                if (rt_bit_reg != '0)
                begin
                    if (rt_x_reg >= rt_trial)
                    begin
                        rt_x_reg   <= rt_x_reg - rt_trial;
                        rt_res_reg <= (rt_res_reg >> 1) + rt_bit_reg;
                    end
                    else
                    begin
                        rt_res_reg <= rt_res_reg >> 1;
                    end
                    rt_bit_reg <= rt_bit_reg >> 2;
                end
                else
                begin
                    sd_reg <= rt_res_reg[Z_W-1:0];
                end
            end
            ST_SCORE_DIV:
            begin
                if (!div_busy)
                begin
                    stat_reg <= drop_reg ? STATUS_OVERFLOW : STATUS_OK;
                    if (diff_reg[Z_W])
                        score_reg <= (div_quo_reg > ACC_W'(24'h800000)) ? SCORE_MIN
                                   : -$signed(div_quo_reg[23:0]);
                    else
                        score_reg <= (div_quo_reg > ACC_W'(24'h7FFFFF)) ? SCORE_MAX
                                   : $signed(div_quo_reg[23:0]);
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_status_reg <= stat_reg;
            o_total_reg  <= count_reg;
            o_mean_reg   <= mean_reg;
            o_diff_reg   <= diff_reg;
            o_range_reg  <= range_reg;
            o_sd_reg     <= sd_reg;
            o_score_reg  <= score_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = o_status_reg;
    assign neighbor_total  = o_total_reg;
    assign mean_z          = o_mean_reg;
    assign diff_from_mean  = o_diff_reg;
    assign z_range         = o_range_reg;
    assign std_dev         = o_sd_reg;
    assign deviation_score = o_score_reg;

endmodule
